[hdl/rbsi_pkg.sv]
// ----------------------------------------------------------------------------
// rbsi_pkg
// Types, constants and codes shared by the ray/box slab test block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DIST_WIDTH  = 31;
  localparam int NUM_AXES    = 3;
  localparam int CFG_IDX_W   = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOW_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_Z = 3'd5;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic signed [COORD_WIDTH-1:0] dir_z;
  } ray_in_t;

  typedef struct packed {
    logic                  hit;
    logic                  origin_inside;
    logic [DIST_WIDTH-1:0] near_distance;
    logic [DIST_WIDTH-1:0] far_distance;
  } ray_out_t;

endpackage

[hdl/ray_box_slab_intersect_core.sv]
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_core
// Ray against axis-aligned box by the slab method, fixed point, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   The box corners are written through cfg_we/cfg_idx/cfg_data while idle.
//   Each input item is one ray (origin, direction). One result item per ray
//   comes out on the out_ channel in order.
//   Three lanes, one per axis, each carry two pipelined restoring dividers
//   with one quotient bit per stage, COORD_WIDTH+1+FRAC_BITS stages (49 at
//   the default widths). A combinational merge and an output register
//   follow.
//   Throughput is one item per cycle. A stall on the out_ side freezes the
//   whole pipeline; in_ready drops only when the output register is full
//   and not being taken.
//   Reset clears valid bits and sets the box corners to zero.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_core #(
  parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rbsi_pkg::ray_in_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rbsi_pkg::ray_out_t   out_data,
  input  logic                 cfg_we,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rbsi_pkg::COORD_WIDTH-1:0] cfg_data
);

  localparam int NA    = rbsi_pkg::NUM_AXES;
  localparam int CW    = rbsi_pkg::COORD_WIDTH;
  localparam int DEPTH = CW + 1 + FRAC_BITS;
  localparam int TW    = DEPTH + 2;

  logic signed [CW-1:0] lo_r [NA];
  logic signed [CW-1:0] hi_r [NA];
  logic signed [CW-1:0] org [NA];
  logic signed [CW-1:0] dir [NA];
  logic signed [TW-1:0] t_en [NA];
  logic signed [TW-1:0] t_ex [NA];
  logic [NA-1:0] dz0, slab0, emp0;
  logic [NA-1:0] dz_r [DEPTH+1];
  logic [NA-1:0] slab_r [DEPTH+1];
  logic [NA-1:0] emp_r [DEPTH+1];
  logic          v_r [DEPTH+1];
  logic          adv;
  logic          out_valid_r;
  rbsi_pkg::ray_out_t res, out_data_r;

  // Pipeline moves whenever the output register can take a new item.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Box corner registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) begin
        lo_r[i] <= '0;
        hi_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        rbsi_pkg::REG_LOW_X:  lo_r[0] <= cfg_data;
        rbsi_pkg::REG_LOW_Y:  lo_r[1] <= cfg_data;
        rbsi_pkg::REG_LOW_Z:  lo_r[2] <= cfg_data;
        rbsi_pkg::REG_HIGH_X: hi_r[0] <= cfg_data;
        rbsi_pkg::REG_HIGH_Y: hi_r[1] <= cfg_data;
        rbsi_pkg::REG_HIGH_Z: hi_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign org[0] = in_data.origin_x;
  assign org[1] = in_data.origin_y;
  assign org[2] = in_data.origin_z;
  assign dir[0] = in_data.dir_x;
  assign dir[1] = in_data.dir_y;
  assign dir[2] = in_data.dir_z;

  // Per-axis lanes and their side flags.
  for (genvar a = 0; a < NA; a++) begin : g_lane
    assign dz0[a]   = (dir[a] == '0);
    assign slab0[a] = (org[a] >= lo_r[a]) && (org[a] <= hi_r[a]);
    assign emp0[a]  = (lo_r[a] > hi_r[a]);
    rbsi_lane #(.CW(CW), .FB(FRAC_BITS), .TW(TW)) u_lane (
      .clk(clk), .adv(adv), .org(org[a]), .dir(dir[a]),
      .lo(lo_r[a]), .hi(hi_r[a]), .t_en(t_en[a]), .t_ex(t_ex[a])
    );
  end

  // Flags and valid bits ride alongside the dividers.
  always_comb begin
    dz_r[0]   = dz0;
    slab_r[0] = slab0;
    emp_r[0]  = emp0;
    v_r[0]    = in_valid;
  end
  for (genvar s = 0; s < DEPTH; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (adv) begin
        v_r[s+1] <= v_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dz_r[s+1]   <= dz_r[s];
        slab_r[s+1] <= slab_r[s];
        emp_r[s+1]  <= emp_r[s];
      end
    end
  end

  rbsi_merge #(.TW(TW)) u_merge (
    .t_en(t_en), .t_ex(t_ex), .dz(dz_r[DEPTH]), .in_slab(slab_r[DEPTH]),
    .empty(emp_r[DEPTH]), .res(res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[DEPTH];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/rbsi_div.sv]
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbsi_div #(
  parameter int NW = 48,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  // Stage s resolves quotient bit NW-1-s.
  logic [NW-1:0] q_r   [NW+1];
  logic [DW-1:0] rem_r [NW+1];
  logic [NW-1:0] n_r   [NW+1];
  logic [DW-1:0] d_r   [NW+1];

  always_comb begin
    q_r[0]   = '0;
    rem_r[0] = '0;
    n_r[0]   = num;
    d_r[0]   = den;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    assign trial = {rem_r[s], n_r[s][NW-1-s]};
    assign diff  = trial - {1'b0, d_r[s]};
    always_ff @(posedge clk) begin
      if (adv) begin
        d_r[s+1] <= d_r[s];
        n_r[s+1] <= n_r[s];
        if (!diff[DW]) begin
          rem_r[s+1] <= diff[DW-1:0];
          q_r[s+1]   <= q_r[s] | (NW'(1) << (NW-1-s));
        end else begin
          rem_r[s+1] <= trial[DW-1:0];
          q_r[s+1]   <= q_r[s];
        end
      end
    end
  end

  assign quo = q_r[NW];

endmodule

[hdl/rbsi_lane.sv]
// ----------------------------------------------------------------------------
// rbsi_lane
// One axis: entry and exit slab parameters, signed and widened.
// ----------------------------------------------------------------------------
module rbsi_lane #(
  parameter int CW = 32,
  parameter int FB = 16,
  parameter int TW = 50
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic signed [CW-1:0] org,
  input  logic signed [CW-1:0] dir,
  input  logic signed [CW-1:0] lo,
  input  logic signed [CW-1:0] hi,
  output logic signed [TW-1:0] t_en,
  output logic signed [TW-1:0] t_ex
);

  localparam int NW = CW + 1 + FB;
  localparam int DW = CW + 1;

  logic signed [CW:0] a_lo, a_hi, d_ext;
  logic signed [CW:0] n_en, n_ex;
  logic               dpos;
  logic [DW-1:0]      ad;
  logic [NW-1:0]      an_en, an_ex, q_en, q_ex;
  logic               neg_en_r [NW+1];
  logic               neg_ex_r [NW+1];

  // Near bound for positive direction is low, else high.
  assign a_lo  = (CW+1)'(lo) - (CW+1)'(org);
  assign a_hi  = (CW+1)'(hi) - (CW+1)'(org);
  assign d_ext = (CW+1)'(dir);
  assign dpos  = !dir[CW-1];
  assign n_en  = dpos ? a_lo : a_hi;
  assign n_ex  = dpos ? a_hi : a_lo;
  assign ad    = dpos ? DW'(d_ext) : DW'(-d_ext);
  assign an_en = NW'(n_en[CW] ? -n_en : n_en) << FB;
  assign an_ex = NW'(n_ex[CW] ? -n_ex : n_ex) << FB;

  // Sign of each quotient travels alongside the divider.
  always_comb begin
    neg_en_r[0] = n_en[CW] ^ !dpos;
    neg_ex_r[0] = n_ex[CW] ^ !dpos;
  end
  for (genvar s = 0; s < NW; s++) begin : g_sgn
    always_ff @(posedge clk) begin
      if (adv) begin
        neg_en_r[s+1] <= neg_en_r[s];
        neg_ex_r[s+1] <= neg_ex_r[s];
      end
    end
  end

  rbsi_div #(.NW(NW), .DW(DW)) u_div_en (
    .clk(clk), .adv(adv), .num(an_en), .den(ad), .quo(q_en)
  );
  rbsi_div #(.NW(NW), .DW(DW)) u_div_ex (
    .clk(clk), .adv(adv), .num(an_ex), .den(ad), .quo(q_ex)
  );

  assign t_en = neg_en_r[NW] ? -TW'(q_en) : TW'(q_en);
  assign t_ex = neg_ex_r[NW] ? -TW'(q_ex) : TW'(q_ex);

endmodule

[hdl/rbsi_merge.sv]
// ----------------------------------------------------------------------------
// rbsi_merge
// Combines the three lanes' slab parameters into one result item.
// ----------------------------------------------------------------------------
module rbsi_merge #(
  parameter int TW = 50
) (
  input  logic signed [TW-1:0] t_en [rbsi_pkg::NUM_AXES],
  input  logic signed [TW-1:0] t_ex [rbsi_pkg::NUM_AXES],
  input  logic [rbsi_pkg::NUM_AXES-1:0] dz,
  input  logic [rbsi_pkg::NUM_AXES-1:0] in_slab,
  input  logic [rbsi_pkg::NUM_AXES-1:0] empty,
  output rbsi_pkg::ray_out_t res
);

  localparam int DW = rbsi_pkg::DIST_WIDTH;

  logic signed [TW-1:0] tn, tf;
  logic                 org_in, miss, unb, nneg;

  function automatic logic [DW-1:0] clampd(input logic signed [TW-1:0] t);
    logic [DW-1:0] r;
    if (t <= 0) r = '0;
    else if (t > $signed({{(TW-DW){1'b0}}, {DW{1'b1}}})) r = '1;
    else r = t[DW-1:0];
    return r;
  endfunction

  // Zero-direction lanes drop out; unbounded stays flagged.
  always_comb begin
    org_in = &in_slab;
    miss   = |empty;
    unb    = 1'b1;
    nneg   = 1'b1;
    tn     = '0;
    tf     = '0;
    for (int i = 0; i < rbsi_pkg::NUM_AXES; i++) begin
      if (dz[i]) begin
        if (!in_slab[i]) miss = 1'b1;
      end else begin
        if (nneg || t_en[i] > tn) tn = t_en[i];
        if (unb || t_ex[i] < tf) tf = t_ex[i];
        nneg = 1'b0;
        unb  = 1'b0;
      end
    end
    res = '0;
    if (org_in) begin
      res.hit           = 1'b1;
      res.origin_inside = 1'b1;
      res.far_distance  = unb ? '1 : clampd(tf);
    end else if (!miss && (unb || (!(!nneg && tn > tf) && !tf[TW-1]))) begin
      res.hit           = 1'b1;
      res.near_distance = nneg ? '0 : clampd(tn);
      res.far_distance  = unb ? '1 : clampd(tf);
    end
  end

endmodule

[verif/rbsi_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_checker
// Watches the ray and result channels of the slab test block, predicts each
// result from the accepted rays and the box it has seen written, and compares.
// ----------------------------------------------------------------------------
module rbsi_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  rbsi_pkg::ray_in_t                    in_data,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  rbsi_pkg::ray_out_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [rbsi_pkg::COORD_WIDTH-1:0]     cfg_data,
  output int                                   fail_count,
  output int                                   pending
);

  localparam longint DMAX = 64'sh7FFFFFFF;
  localparam longint TPOS = 64'sh7FFFFFFFFFFFFFFF;
  localparam longint TNEG = -64'sh7FFFFFFFFFFFFFFF - 1;

  longint box_lo[3];
  longint box_hi[3];
  rbsi_pkg::ray_out_t hit_queue[$];

  // Exact (num << FRAC_BITS) / den on magnitudes, truncated toward zero.
  function automatic longint slab_param(longint num, longint den);
    logic neg;
    longint unsigned an, ad, q;
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (an << rbsi_pkg::FRAC_BITS) / ad;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [rbsi_pkg::DIST_WIDTH-1:0] clamp_t(longint t);
    if (t <= 0) return '0;
    if (t > DMAX) return '1;
    return t[rbsi_pkg::DIST_WIDTH-1:0];
  endfunction

  function automatic rbsi_pkg::ray_out_t trace_ray(rbsi_pkg::ray_in_t r);
    longint o[3], d[3];
    longint tn, tf, ten, tex;
    logic org_in, miss;
    rbsi_pkg::ray_out_t res;
    o[0] = longint'(r.origin_x); o[1] = longint'(r.origin_y);
    o[2] = longint'(r.origin_z);
    d[0] = longint'(r.dir_x); d[1] = longint'(r.dir_y); d[2] = longint'(r.dir_z);
    tn = TNEG; tf = TPOS; org_in = 1'b1; miss = 1'b0;
    for (int i = 0; i < 3; i++)
      if (o[i] < box_lo[i] || o[i] > box_hi[i]) org_in = 1'b0;
    res = '0;
    if (org_in) begin
      // Origin in the box: exit only over axes that move.
      for (int i = 0; i < 3; i++) begin
        if (d[i] != 0) begin
          ten = slab_param((d[i] > 0 ? box_hi[i] : box_lo[i]) - o[i], d[i]);
          if (ten < tf) tf = ten;
        end
      end
      res.hit = 1'b1;
      res.origin_inside = 1'b1;
      res.far_distance = clamp_t(tf);
      return res;
    end
    // Slab test on each axis.
    for (int i = 0; i < 3; i++) begin
      if (box_lo[i] > box_hi[i]) miss = 1'b1;
      else if (d[i] == 0) begin
        if (o[i] < box_lo[i] || o[i] > box_hi[i]) miss = 1'b1;
      end else begin
        if (d[i] > 0) begin
          ten = slab_param(box_lo[i] - o[i], d[i]);
          tex = slab_param(box_hi[i] - o[i], d[i]);
        end else begin
          ten = slab_param(box_hi[i] - o[i], d[i]);
          tex = slab_param(box_lo[i] - o[i], d[i]);
        end
        if (ten > tn) tn = ten;
        if (tex < tf) tf = tex;
      end
    end
    if (!miss && (tn > tf || tf < 0)) miss = 1'b1;
    if (miss) return res;
    res.hit = 1'b1;
    res.near_distance = clamp_t(tn);
    res.far_distance = clamp_t(tf);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Predict on accepted rays, compare on accepted results.
  always @(posedge clk) begin
    rbsi_pkg::ray_out_t want;
    if (!rst_n) begin
      fail_count = 0;
      for (int i = 0; i < 3; i++) begin
        box_lo[i] = 0;
        box_hi[i] = 0;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (hit_queue.size() == 0) begin
          report_mismatch("unexpected item", out_data, 0);
        end else begin
          want = hit_queue.pop_front();
          if (out_data.hit !== want.hit)
            report_mismatch("hit", out_data.hit, want.hit);
          if (out_data.origin_inside !== want.origin_inside)
            report_mismatch("origin_inside", out_data.origin_inside, want.origin_inside);
          if (out_data.near_distance !== want.near_distance)
            report_mismatch("near_distance", out_data.near_distance, want.near_distance);
          if (out_data.far_distance !== want.far_distance)
            report_mismatch("far_distance", out_data.far_distance, want.far_distance);
        end
      end
      if (in_valid && in_ready) hit_queue.push_back(trace_ray(in_data));
      if (cfg_we) begin
        if (cfg_idx <= rbsi_pkg::REG_LOW_Z) box_lo[cfg_idx] = longint'($signed(cfg_data));
        else if (cfg_idx <= rbsi_pkg::REG_HIGH_Z)
          box_hi[cfg_idx - rbsi_pkg::REG_HIGH_X] = longint'($signed(cfg_data));
      end
    end
    pending = hit_queue.size();
  end
endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives rays and box settings into the slab test block under random
// handshake pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LATENCY = rbsi_pkg::COORD_WIDTH + 1 + rbsi_pkg::FRAC_BITS + 2;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rbsi_pkg::ray_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rbsi_pkg::ray_out_t out_data;
  logic cfg_we = 1'b0;
  logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [rbsi_pkg::COORD_WIDTH-1:0] cfg_data = '0;
  int fail_count, pending;
  longint cycles = 0;
  logic calm = 1'b0;
  logic hold_long = 1'b0;

  always #2 clk = ~clk;

  ray_box_slab_intersect_core dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  rbsi_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off, none once calm.
  initial begin
    int n;
    logic held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_long && !held) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // The write enable stays high; the caller drops it after the last write.
  task automatic write_box(input logic [rbsi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic set_box(input logic [31:0] lx, ly, lz, hx, hy, hz);
    write_box(rbsi_pkg::REG_LOW_X, lx); write_box(rbsi_pkg::REG_LOW_Y, ly);
    write_box(rbsi_pkg::REG_LOW_Z, lz);
    write_box(rbsi_pkg::REG_HIGH_X, hx); write_box(rbsi_pkg::REG_HIGH_Y, hy);
    write_box(rbsi_pkg::REG_HIGH_Z, hz);
    cfg_we <= 1'b0;
  endtask

  // Offer one ray, with an optional random gap first; valid stays high after.
  task automatic send_ray(input rbsi_pkg::ray_in_t r, input logic gaps);
    int n;
    if (gaps && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 13);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 40) * 32'h0001_0000 - 32'h0014_0000;
      2: return ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
      default: return $signed($urandom_range(0, 2048)) - 1024;
    endcase
  endfunction

  function automatic rbsi_pkg::ray_in_t rand_ray(int style);
    rbsi_pkg::ray_in_t r;
    r.origin_x = rand_coord(style == 0 ? 0 : $urandom_range(0, 3) ? 1 : $urandom_range(0, 3));
    r.origin_y = rand_coord(style == 0 ? 0 : $urandom_range(0, 3) ? 1 : $urandom_range(0, 3));
    r.origin_z = rand_coord(style == 0 ? 0 : $urandom_range(0, 3) ? 1 : $urandom_range(0, 3));
    r.dir_x = $urandom_range(0, 7) == 0 ? 0 : rand_coord($urandom_range(0, 3));
    r.dir_y = $urandom_range(0, 7) == 0 ? 0 : rand_coord($urandom_range(0, 3));
    r.dir_z = $urandom_range(0, 7) == 0 ? 0 : rand_coord($urandom_range(0, 3));
    return r;
  endfunction

  initial begin
    rbsi_pkg::ray_in_t r;
    logic [31:0] lo, hi;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rays against the reset (point) box, then a unit-scale box.
    send_ray('0, 1'b0);
    send_ray({32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0);
    drain();
    set_box(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
            32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    // Inside, all directions zero: unbounded far distance.
    send_ray('0, 1'b0);
    // Inside on the bound, moving out and moving in.
    send_ray({32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0}, 1'b0);
    send_ray({32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0003_0000, 32'h0}, 1'b0);
    // Outside, heading straight in; outside heading away (box behind).
    send_ray({32'hFFFB_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0}, 1'b0);
    send_ray({32'hFFFB_0000, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0}, 1'b0);
    // Zero direction axis outside its slab misses.
    send_ray({32'hFFFB_0000, 32'h0005_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0}, 1'b0);
    // Field extremes, tiny and huge directions, saturated distances.
    send_ray({32'h8000_0000, 32'h0, 32'h0, 32'h0000_0001, 32'h0, 32'h0}, 1'b0);
    send_ray({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0);
    send_ray({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0);
    send_ray({32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1}, 1'b0);
    send_ray({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0);
    // Diagonal miss: slabs overlap in no interval.
    send_ray({32'hFFFB_0000, 32'h0005_0000, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0},
             1'b0);
    drain();
    // Inverted box misses everywhere; extreme corners.
    set_box(32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
    send_ray({32'hFFFB_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0}, 1'b0);
    send_ray('0, 1'b0);
    drain();
    set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_ray({32'h0, 32'h0, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0}, 1'b0);
    send_ray({32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0);
    drain();

    // Random phases, each with a fresh box.
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 13) calm = 1'b1;
      if (ph % 4 == 3) begin
        set_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        lo = rand_coord(1); hi = lo + $urandom_range(0, 12) * 32'h0001_0000;
        write_box(rbsi_pkg::REG_LOW_X, lo); write_box(rbsi_pkg::REG_HIGH_X, hi);
        lo = rand_coord(1); hi = lo + $urandom_range(0, 12) * 32'h0001_0000;
        write_box(rbsi_pkg::REG_LOW_Y, lo); write_box(rbsi_pkg::REG_HIGH_Y, hi);
        lo = rand_coord(1); hi = lo + $urandom_range(1, 12) * 32'h0001_0000;
        write_box(rbsi_pkg::REG_LOW_Z, lo); write_box(rbsi_pkg::REG_HIGH_Z, hi);
        cfg_we <= 1'b0;
      end
      if (ph == 5) hold_long = 1'b1;
      for (int k = 0; k < 102; k++) begin
        r = rand_ray($urandom_range(0, 4) == 0 ? 0 : 1);
        send_ray(r, 1'b1);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

[files.f]
hdl/rbsi_pkg.sv
hdl/rbsi_div.sv
hdl/rbsi_lane.sv
hdl/rbsi_merge.sv
hdl/ray_box_slab_intersect_core.sv
verif/rbsi_checker.sv
verif/tb_top.sv
